FILE: rtl/core/hfx_pkg.sv
package hfx_pkg;

    // byte counter width inside the parser
    localparam int COUNT_WIDTH = 16;
    localparam int LEN_WIDTH   = 16;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_FORMAT    = 2'd3;

    // first member sits in the high bits, so mantissa lands lowest in tdata
    typedef struct packed {
        logic [LEN_WIDTH-1:0] consumed_length;
        logic [1:0]           status;
        logic [15:0]          sign_exponent;
        logic [63:0]          mantissa;
    } hfx_result_t;

    localparam int RESULT_BITS = $bits(hfx_result_t);
    localparam int TDATA_OUT_W = ((RESULT_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/core/hfx_core.sv
module hfx_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_code,
    input  logic                string_start,
    input  logic                strict_full_match,
    output logic                res_valid,
    output hfx_pkg::hfx_result_t res
);
    import hfx_pkg::*;

    localparam logic [3:0] PH_WAIT   = 4'd0;
    localparam logic [3:0] PH_NAN1   = 4'd1;
    localparam logic [3:0] PH_NAN2   = 4'd2;
    localparam logic [3:0] PH_SIGNED = 4'd3;
    localparam logic [3:0] PH_INF1   = 4'd4;
    localparam logic [3:0] PH_INF2   = 4'd5;
    localparam logic [3:0] PH_X      = 4'd6;
    localparam logic [3:0] PH_HEX1   = 4'd7;
    localparam logic [3:0] PH_INT    = 4'd8;
    localparam logic [3:0] PH_FRAC   = 4'd9;
    localparam logic [3:0] PH_ESIGN  = 4'd10;
    localparam logic [3:0] PH_EDIG1  = 4'd11;
    localparam logic [3:0] PH_EDIG   = 4'd12;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [19:0]            EXP_CAP = 20'd100000;

    function automatic logic [COUNT_WIDTH-1:0] cnt_plus(
        input logic [COUNT_WIDTH-1:0] c, input logic [1:0] n);
        logic [COUNT_WIDTH+1:0] s;
        begin
            s = {2'b00, c} + {{COUNT_WIDTH{1'b0}}, n};
            cnt_plus = (s > {2'b00, CNT_MAX}) ? CNT_MAX : s[COUNT_WIDTH-1:0];
        end
    endfunction

    function automatic logic [LEN_WIDTH-1:0] to_len(input logic [COUNT_WIDTH-1:0] c);
        logic [33:0] w;
        begin
            w = 34'(c);
            to_len = (w > 34'(16'hFFFF)) ? 16'hFFFF : w[LEN_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [19:0] adj_sat(
        input logic signed [19:0] a, input logic signed [3:0] v);
        logic signed [20:0] r;
        begin
            r = {a[19], a} + {{17{v[3]}}, v};
            if (r > 21'sd524287)
                adj_sat = 20'sd524287;
            else if (r < -21'sd524288)
                adj_sat = -20'sd524288;
            else
                adj_sat = r[19:0];
        end
    endfunction

    // parser state
    logic [3:0]         phase_reg, phase_next;
    logic [63:0]        mant_reg, mant_next;
    logic signed [6:0]  shift_reg, shift_next;
    logic signed [19:0] adj_reg, adj_next;
    logic               seen_reg, seen_next;
    logic               neg_reg, neg_next;
    logic               eneg_reg, eneg_next;
    logic [19:0]        ev_reg, ev_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic               given_reg, given_next;

    // state seen by this byte (a string start restarts the parse)
    logic [3:0]         cur_phase;
    logic [63:0]        cur_mant;
    logic signed [6:0]  cur_shift;
    logic signed [19:0] cur_adj;
    logic               cur_seen;
    logic               cur_neg;
    logic               cur_eneg;
    logic [19:0]        cur_ev;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic               cur_given;

    assign cur_phase = string_start ? PH_WAIT : phase_reg;
    assign cur_mant  = string_start ? 64'd0 : mant_reg;
    assign cur_shift = string_start ? 7'sd60 : shift_reg;
    assign cur_adj   = string_start ? 20'sd0 : adj_reg;
    assign cur_seen  = string_start ? 1'b0 : seen_reg;
    assign cur_neg   = string_start ? 1'b0 : neg_reg;
    assign cur_eneg  = string_start ? 1'b0 : eneg_reg;
    assign cur_ev    = string_start ? 20'd0 : ev_reg;
    assign cur_cnt   = string_start ? '0 : cnt_reg;
    assign cur_given = string_start ? 1'b0 : given_reg;

    // character classes
    logic [7:0] lc;
    logic       is_dec, is_hex, is_space, is_sign, is_minus;
    logic [3:0] hval;
    logic [1:0] lead_k;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    assign lc       = char_code | 8'h20;
    assign is_dec   = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign is_hex   = is_dec || ((lc >= 8'h61) && (lc <= 8'h66));
    assign hval     = is_dec ? char_code[3:0] : 4'(char_code[3:0] + 4'd9);
    assign is_space = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
    assign is_sign  = (char_code == 8'h2B) || (char_code == 8'h2D);
    assign is_minus = (char_code == 8'h2D);
    assign lead_k   = hval[3] ? 2'd0 : hval[2] ? 2'd1 : hval[1] ? 2'd2 : 2'd3;
    assign cnt_inc  = cnt_plus(cur_cnt, 2'd1);

    // digit placement
    logic [63:0]       put_mant, lead_mant;
    logic signed [6:0] put_shift, shift_m4;
    logic [1:0]        neg_amt;

    assign shift_m4  = cur_shift - 7'sd4;
    assign put_shift = (shift_m4 < -7'sd4) ? -7'sd4 : shift_m4;
    assign neg_amt   = 2'(-cur_shift);
    assign lead_mant = (64'(hval) << 60) << lead_k;

    always_comb
    begin
        if (cur_shift >= 7'sd0)
            put_mant = cur_mant | (64'(hval) << cur_shift[5:0]);
        else if (cur_shift > -7'sd4)
            put_mant = cur_mant | 64'(hval >> neg_amt);
        else
            put_mant = cur_mant;
    end

    // final exponent
    logic signed [22:0] ev_s, exp_full;
    assign ev_s     = $signed({3'b000, cur_ev});
    assign exp_full = (cur_eneg ? -ev_s : ev_s) + 23'sd16383 + {{3{cur_adj[19]}}, cur_adj};

    logic signed [3:0] frac_step;
    assign frac_step = (hval == 4'd0) ? -4'sd4 : -$signed({2'b00, lead_k}) - 4'sd1;

    logic do_digit, int_mode, signed_chk, edig1_chk, fail, finish;

    always_comb
    begin
        phase_next = cur_phase;
        mant_next  = cur_mant;
        shift_next = cur_shift;
        adj_next   = cur_adj;
        seen_next  = cur_seen;
        neg_next   = cur_neg;
        eneg_next  = cur_eneg;
        ev_next    = cur_ev;
        cnt_next   = cur_cnt;
        given_next = cur_given;
        res_valid  = 1'b0;
        res        = '0;
        do_digit   = 1'b0;
        int_mode   = 1'b0;
        signed_chk = 1'b0;
        edig1_chk  = 1'b0;
        fail       = 1'b0;
        finish     = 1'b0;

        if (!cur_given)
        begin
            case (cur_phase)
                PH_WAIT:
                begin
                    if (is_space)
                        cnt_next = cnt_inc;
                    else if (lc == 8'h6E)
                        phase_next = PH_NAN1;
                    else if (is_sign)
                    begin
                        neg_next   = is_minus;
                        cnt_next   = cnt_inc;
                        phase_next = PH_SIGNED;
                    end
                    else
                        signed_chk = 1'b1;
                end
                PH_SIGNED: signed_chk = 1'b1;
                PH_NAN1:
                begin
                    if (lc == 8'h61) phase_next = PH_NAN2;
                    else fail = 1'b1;
                end
                PH_NAN2:
                begin
                    if (lc == 8'h6E)
                    begin
                        res_valid  = 1'b1;
                        res.mantissa        = 64'hC000_0000_0000_0000;
                        res.sign_exponent   = 16'hFFFF;
                        res.status          = ST_OK;
                        res.consumed_length = to_len(cnt_plus(cur_cnt, 2'd3));
                        given_next = 1'b1;
                    end
                    else
                        fail = 1'b1;
                end
                PH_INF1:
                begin
                    if (lc == 8'h6E) phase_next = PH_INF2;
                    else fail = 1'b1;
                end
                PH_INF2:
                begin
                    if (lc == 8'h66)
                    begin
                        res_valid  = 1'b1;
                        res.mantissa        = 64'h8000_0000_0000_0000;
                        res.sign_exponent   = {cur_neg, 15'h7FFF};
                        res.status          = ST_OK;
                        res.consumed_length = to_len(cnt_plus(cur_cnt, 2'd3));
                        given_next = 1'b1;
                    end
                    else
                        fail = 1'b1;
                end
                PH_X:
                begin
                    if (lc == 8'h78)
                    begin
                        cnt_next   = cnt_inc;
                        phase_next = PH_HEX1;
                    end
                    else
                        fail = 1'b1;
                end
                PH_HEX1:
                begin
                    if (is_hex)
                    begin
                        cnt_next   = cnt_inc;
                        do_digit   = 1'b1;
                        int_mode   = 1'b1;
                        phase_next = PH_INT;
                    end
                    else
                        fail = 1'b1;
                end
                PH_INT, PH_FRAC:
                begin
                    if (is_hex)
                    begin
                        cnt_next = cnt_inc;
                        do_digit = 1'b1;
                        int_mode = (cur_phase == PH_INT);
                    end
                    else if (char_code == 8'h2E && cur_phase == PH_INT)
                    begin
                        cnt_next   = cnt_inc;
                        phase_next = PH_FRAC;
                    end
                    else if (lc == 8'h70)
                    begin
                        cnt_next   = cnt_inc;
                        phase_next = PH_ESIGN;
                    end
                    else
                        fail = 1'b1;
                end
                PH_ESIGN:
                begin
                    if (is_sign)
                    begin
                        eneg_next  = is_minus;
                        cnt_next   = cnt_inc;
                        phase_next = PH_EDIG1;
                    end
                    else
                        edig1_chk = 1'b1;
                end
                PH_EDIG1: edig1_chk = 1'b1;
                PH_EDIG:
                begin
                    if (is_dec)
                    begin
                        cnt_next = cnt_inc;
                        if (cur_ev < EXP_CAP)
                            ev_next = (cur_ev << 3) + (cur_ev << 1) + 20'(char_code[3:0]);
                    end
                    else if (char_code != 8'h00 && strict_full_match)
                        fail = 1'b1;
                    else
                        finish = 1'b1;
                end
                default: fail = 1'b1;
            endcase

            // sign seen (or none), expect inf or 0x
            if (signed_chk)
            begin
                if (lc == 8'h69)
                    phase_next = PH_INF1;
                else if (char_code == 8'h30)
                begin
                    cnt_next   = cnt_inc;
                    phase_next = PH_X;
                end
                else
                    fail = 1'b1;
            end

            // first exponent digit
            if (edig1_chk)
            begin
                if (is_dec)
                begin
                    ev_next    = 20'(char_code[3:0]);
                    cnt_next   = cnt_inc;
                    phase_next = PH_EDIG;
                end
                else
                    fail = 1'b1;
            end

            if (do_digit)
            begin
                if (cur_seen)
                begin
                    mant_next  = put_mant;
                    shift_next = put_shift;
                    if (int_mode)
                        adj_next = adj_sat(cur_adj, 4'sd4);
                end
                else if (hval != 4'd0)
                begin
                    mant_next  = lead_mant;
                    shift_next = 7'sd56 + $signed({5'b00000, lead_k});
                    seen_next  = 1'b1;
                    if (int_mode)
                        adj_next = 20'sd3 - $signed({18'd0, lead_k});
                    else
                        adj_next = adj_sat(cur_adj, frac_step);
                end
                else if (!int_mode)
                    adj_next = adj_sat(cur_adj, -4'sd4);
            end

            if (fail)
            begin
                res_valid  = 1'b1;
                res.status = ST_FORMAT;
                res.consumed_length = to_len(cur_cnt);
                given_next = 1'b1;
            end

            if (finish)
            begin
                res_valid  = 1'b1;
                res.consumed_length = to_len(cur_cnt);
                given_next = 1'b1;
                if (cur_mant == 64'd0)
                begin
                    res.sign_exponent = {cur_neg, 15'h0000};
                    res.status        = ST_OK;
                end
                else if (exp_full < 23'sd0)
                begin
                    res.sign_exponent = {cur_neg, 15'h0000};
                    res.status        = ST_UNDERFLOW;
                end
                else if (exp_full > 23'sd32767)
                begin
                    res.mantissa      = 64'h8000_0000_0000_0000;
                    res.sign_exponent = {cur_neg, 15'h7FFF};
                    res.status        = ST_OVERFLOW;
                end
                else
                begin
                    res.mantissa      = cur_mant;
                    res.sign_exponent = {cur_neg, exp_full[14:0]};
                    res.status        = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            mant_reg  <= 64'd0;
            shift_reg <= 7'sd60;
            adj_reg   <= 20'sd0;
            seen_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            eneg_reg  <= 1'b0;
            ev_reg    <= 20'd0;
            cnt_reg   <= '0;
            given_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            mant_reg  <= mant_next;
            shift_reg <= shift_next;
            adj_reg   <= adj_next;
            seen_reg  <= seen_next;
            neg_reg   <= neg_next;
            eneg_reg  <= eneg_next;
            ev_reg    <= ev_next;
            cnt_reg   <= cnt_next;
            given_reg <= given_next;
        end
    end

endmodule

FILE: rtl/core/hex_float_to_extended_parser_top.sv
// Parses a C99 hexadecimal float literal, fed one text byte per item, into an
// x87 80-bit extended value. Input items carry one byte; tuser marks the first
// byte of a new string. One result item comes out per string: on the third
// letter of nan/inf, on the byte that ends the exponent digits, or on the
// first byte that breaks the format; later bytes are dropped until the next
// string start. Rate is one input item per clock while s_axis_tready is high;
// it falls only when both output slots are full. Each byte is parsed in one
// pass of logic on the parser state registers, its result registered into
// the first free slot of a two-deep output stage (result and skid registers)
// that keeps input open while a result waits. The user writes strict_full_match
// via cfg_we/cfg_wdata only while no string is in flight; not enforced.
module hex_float_to_extended_parser_top (
    input  logic        clk,
    input  logic        rst_n,

    // configuration: strict_full_match
    input  logic        cfg_we,
    input  logic        cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] string_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [63:0] mantissa, [79:64] sign_exponent, [81:80] status,
    // [97:82] consumed_length, upper bits zero
    output logic [hfx_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import hfx_pkg::*;

    logic        strict_reg;
    logic        in_accept;
    logic        res_valid;
    hfx_result_t res;

    // output stage: result register and skid register
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    hfx_result_t out_data_reg, out_data_next;
    hfx_result_t skid_data_reg, skid_data_next;
    logic        take;

    // input stalls only when both output slots are full
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign take          = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W - RESULT_BITS){1'b0}}, out_data_reg};

    // the byte parser with its state
    hfx_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .char_code         (s_axis_tdata),
        .string_start      (s_axis_tuser),
        .strict_full_match (strict_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        // drain: the skid item moves up when the result register empties
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end

        // fill: a new result goes to the first free slot
        if (in_accept && res_valid)
        begin
            if (!out_valid_next)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            strict_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_we)
                strict_reg <= cfg_wdata;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: tb/hfx_checker.sv
`timescale 1ns / 1ps

// watches both streams and the config port, predicts each result item and
// compares it field by field with what the parser hands out
module hfx_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [hfx_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output int                              errors,
    output int                              outstanding,
    output int                              checked
);
    import hfx_pkg::*;

    typedef enum logic [3:0] {
        P_WAIT, P_NAN1, P_NAN2, P_SIGNED, P_INF1, P_INF2, P_X,
        P_HEX1, P_INT, P_FRAC, P_ESIGN, P_EDIG1, P_EDIG
    } parse_phase_t;

    localparam int ADJ_MAX = 524287;
    localparam int ADJ_MIN = -524288;
    localparam int EXP_BIAS = 16383;
    localparam int EXP_TOP = 32767;
    localparam int EXP_CAP = 100000;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [63:0] MANT_NAN = 64'hC000_0000_0000_0000;
    localparam logic [63:0] MANT_INF = 64'h8000_0000_0000_0000;

    parse_phase_t    phase = P_WAIT;
    logic [63:0]     mant_acc = '0;
    int              nib_shift = 60;
    int              exp_adj = 0;
    bit              lead_seen = 0;
    bit              neg_value = 0;
    bit              neg_exp = 0;
    int              exp_val = 0;
    longint unsigned nbytes = 0;
    bit              result_sent = 0;
    bit              strict_mode = 0;
    int              fail_count = 0;
    int              match_count = 0;

    hfx_result_t expected_q[$];

    assign errors  = fail_count;
    assign checked = match_count;

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic longint unsigned sat_count(longint unsigned c, int n);
        return (c + n > COUNT_MAX) ? COUNT_MAX : c + n;
    endfunction

    task automatic reset_parse();
        phase       = P_WAIT;
        mant_acc    = '0;
        nib_shift   = 60;
        exp_adj     = 0;
        lead_seen   = 0;
        neg_value   = 0;
        neg_exp     = 0;
        exp_val     = 0;
        nbytes      = 0;
        result_sent = 0;
    endtask

    task automatic push_result(logic [63:0] mant, logic [15:0] se, logic [1:0] st,
                               longint unsigned len);
        hfx_result_t r;
        r.mantissa        = mant;
        r.sign_exponent   = se;
        r.status          = st;
        r.consumed_length = (len > 64'hFFFF) ? 16'hFFFF : len[LEN_WIDTH-1:0];
        expected_q.push_back(r);
        result_sent = 1;
    endtask

    task automatic format_error();
        push_result('0, '0, ST_FORMAT, nbytes);
    endtask

    task automatic bump_adj(int v);
        int r;
        r = exp_adj + v;
        if (r > ADJ_MAX)
            r = ADJ_MAX;
        if (r < ADJ_MIN)
            r = ADJ_MIN;
        exp_adj = r;
    endtask

    task automatic place_digit(int d);
        if (nib_shift >= 0)
            mant_acc |= 64'(d) << nib_shift;
        else if (nib_shift > -4)
            mant_acc |= 64'(d) >> (-nib_shift);
        nib_shift -= 4;
        if (nib_shift < -4)
            nib_shift = -4;
    endtask

    // first nonzero nibble: its top set bit becomes the explicit integer bit
    function automatic int lead_nibble(int d);
        int k;
        k = (d >= 8) ? 0 : (d >= 4) ? 1 : (d >= 2) ? 2 : 3;
        mant_acc |= 64'(d) << (60 + k);
        nib_shift = 56 + k;
        lead_seen = 1;
        return k;
    endfunction

    task automatic int_nibble(int d);
        if (lead_seen)
        begin
            bump_adj(4);
            place_digit(d);
        end
        else if (d > 0)
            exp_adj = 3 - lead_nibble(d);
    endtask

    task automatic frac_nibble(int d);
        if (lead_seen)
            place_digit(d);
        else if (d == 0)
            bump_adj(-4);
        else
            bump_adj(-(1 + lead_nibble(d)));
    endtask

    task automatic finish_literal();
        int e;
        if (mant_acc == 0)
        begin
            push_result('0, {neg_value, 15'h0}, ST_OK, nbytes);
            return;
        end
        e = (neg_exp ? -exp_val : exp_val) + EXP_BIAS + exp_adj;
        if (e < 0)
            push_result('0, {neg_value, 15'h0}, ST_UNDERFLOW, nbytes);
        else if (e > EXP_TOP)
            push_result(MANT_INF, {neg_value, 15'h7FFF}, ST_OVERFLOW, nbytes);
        else
            push_result(mant_acc, {neg_value, 15'(e)}, ST_OK, nbytes);
    endtask

    task automatic after_sign(logic [7:0] c);
        if (c == "i" || c == "I")
            phase = P_INF1;
        else if (c == "0")
        begin
            nbytes = sat_count(nbytes, 1);
            phase  = P_X;
        end
        else
            format_error();
    endtask

    task automatic first_exp_digit(logic [7:0] c);
        if (c < "0" || c > "9")
            format_error();
        else
        begin
            exp_val = int'(c - "0");
            nbytes  = sat_count(nbytes, 1);
            phase   = P_EDIG;
        end
    endtask

    task automatic parse_byte(logic [7:0] c, logic first);
        int d;
        d = hex_digit(c);
        if (first)
            reset_parse();
        if (result_sent)
            return;
        case (phase)
            P_WAIT:
                if (c == " " || (c >= 8'd9 && c <= 8'd13))
                    nbytes = sat_count(nbytes, 1);
                else if (c == "n" || c == "N")
                    phase = P_NAN1;
                else if (c == "+" || c == "-")
                begin
                    neg_value = (c == "-");
                    nbytes    = sat_count(nbytes, 1);
                    phase     = P_SIGNED;
                end
                else
                    after_sign(c);
            P_SIGNED:
                after_sign(c);
            P_NAN1:
                if (c == "a" || c == "A")
                    phase = P_NAN2;
                else
                    format_error();
            P_NAN2:
                if (c == "n" || c == "N")
                    push_result(MANT_NAN, 16'hFFFF, ST_OK, sat_count(nbytes, 3));
                else
                    format_error();
            P_INF1:
                if (c == "n" || c == "N")
                    phase = P_INF2;
                else
                    format_error();
            P_INF2:
                if (c == "f" || c == "F")
                    push_result(MANT_INF, {neg_value, 15'h7FFF}, ST_OK,
                                sat_count(nbytes, 3));
                else
                    format_error();
            P_X:
                if (c == "x" || c == "X")
                begin
                    nbytes = sat_count(nbytes, 1);
                    phase  = P_HEX1;
                end
                else
                    format_error();
            P_HEX1:
                if (d < 0)
                    format_error();
                else
                begin
                    nbytes = sat_count(nbytes, 1);
                    int_nibble(d);
                    phase = P_INT;
                end
            P_INT, P_FRAC:
                if (d >= 0)
                begin
                    nbytes = sat_count(nbytes, 1);
                    if (phase == P_INT)
                        int_nibble(d);
                    else
                        frac_nibble(d);
                end
                else if (c == "." && phase == P_INT)
                begin
                    nbytes = sat_count(nbytes, 1);
                    phase  = P_FRAC;
                end
                else if (c == "p" || c == "P")
                begin
                    nbytes = sat_count(nbytes, 1);
                    phase  = P_ESIGN;
                end
                else
                    format_error();
            P_ESIGN:
                if (c == "+" || c == "-")
                begin
                    neg_exp = (c == "-");
                    nbytes  = sat_count(nbytes, 1);
                    phase   = P_EDIG1;
                end
                else
                    first_exp_digit(c);
            P_EDIG1:
                first_exp_digit(c);
            P_EDIG:
                if (c >= "0" && c <= "9")
                begin
                    nbytes = sat_count(nbytes, 1);
                    if (exp_val < EXP_CAP)
                        exp_val = exp_val * 10 + int'(c - "0");
                end
                else if (c != 8'h00 && strict_mode)
                    format_error();
                else
                    finish_literal();
            default:
                format_error();
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        hfx_result_t got;
        hfx_result_t want;
        if (!rst_n)
        begin
            strict_mode = 0;
            reset_parse();
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RESULT_BITS-1:0];
                if (expected_q.size() == 0)
                begin
                    $error("result item with nothing expected, mantissa %0h", got.mantissa);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    match_count++;
                    check_field("mantissa", want.mantissa, got.mantissa);
                    check_field("sign_exponent", 64'(want.sign_exponent),
                                64'(got.sign_exponent));
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("consumed_length", 64'(want.consumed_length),
                                64'(got.consumed_length));
                end
            end
            if (cfg_we)
                strict_mode = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser);
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: tb/tb_hex_float_to_extended_parser_top.sv
`timescale 1ns / 1ps

// stimulus and verdict for the hex float parser; all prediction and
// comparison lives in hfx_checker
module tb_hex_float_to_extended_parser_top;
    import hfx_pkg::*;

    // generous cycle budget for the whole run
    localparam int LIMIT       = 100_000;
    // long receiver hold-off so the two-deep output stage fills and stalls input
    localparam int HOLD_LEN    = 400;
    // long digit runs, well past the 64-bit significand
    localparam int LONG_RUN    = 40;
    // random items per idling phase
    localparam int PHASE_ITEMS = 300;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [7:0] char_code
    logic                   s_axis_tuser = 1'b0; // [0] string_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [63:0] mantissa, [79:64] sign_exponent, [81:80] status,
    // [97:82] consumed_length
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    // knobs for the idling phases, in percent
    int idle_pct = 0;
    int stall_pct = 0;

    // receiver hold-off request: toggled by the stimulus, counted by the receiver
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int cycles = 0;
    int items_sent = 0;
    int strings_sent = 0;
    int errors;
    int outstanding;
    int checked;

    // text of the string being built, one byte per item
    logic [7:0] text_q[$];

    always #5 clk = ~clk;

    hex_float_to_extended_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hfx_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_seen     <= 1'b0;
            hold_left     <= 0;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen     <= hold_go;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // offer one item, with random idle cycles first, and wait until it is taken;
    // tvalid stays high on return so back-to-back items need no re-raise
    task automatic send_item(logic [7:0] c, logic first);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // send the built text as one string: string_start on its first byte
    task automatic send_text();
        if (text_q.size() == 0)
            return;
        foreach (text_q[i])
            send_item(text_q[i], i == 0);
        strings_sent++;
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // a directed literal closed by NUL
    task automatic run_str(string s);
        text_q.delete();
        add_str(s);
        text_q.push_back(8'h00);
        send_text();
    endtask

    // sender goes quiet until every predicted result has been taken, then lets the
    // output stage settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_strict(bit v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(int d);
        logic [7:0] c;
        c = (d < 10) ? 8'(8'h30 + d) : 8'(8'h61 + d - 10);
        if (d >= 10 && $urandom_range(0, 1))
            c = c - 8'h20;
        return c;
    endfunction

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic [7:0] blank_char();
        int sel;
        sel = $urandom_range(0, 5);
        return (sel == 0) ? 8'h20 : 8'(8 + sel);
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        return $urandom_range(0, 1) ? (c ^ 8'h20) : c;
    endfunction

    // well-formed hex literal with random content
    task automatic make_literal();
        int         n;
        bit         all_zero;
        longint     ev;
        logic [7:0] b;
        text_q.delete();
        repeat ($urandom_range(0, 2))
            text_q.push_back(blank_char());
        case ($urandom_range(0, 2))
            1: text_q.push_back("+");
            2: text_q.push_back("-");
            default: ;
        endcase
        text_q.push_back("0");
        text_q.push_back($urandom_range(0, 1) ? "x" : "X");
        all_zero = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                text_q.push_back("0");
        // long runs push bits past the 64-bit significand
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4);
        repeat (n)
            text_q.push_back(hex_char(all_zero ? 0 : $urandom_range(0, 15)));
        if ($urandom_range(0, 1))
        begin
            text_q.push_back(".");
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 5))
                    text_q.push_back("0");
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            repeat (n)
                text_q.push_back(hex_char(all_zero ? 0 : $urandom_range(0, 15)));
        end
        text_q.push_back($urandom_range(0, 1) ? "p" : "P");
        case ($urandom_range(0, 2))
            1: text_q.push_back("+");
            2: text_q.push_back("-");
            default: ;
        endcase
        // exponent classes: small, around the bias edges, mid, around the
        // growth cap, and huge
        case ($urandom_range(0, 5))
            0, 1: ev = $urandom_range(0, 40);
            2: ev = $urandom_range(16300, 16460);
            3: ev = $urandom_range(0, 5000);
            4: ev = $urandom_range(99990, 100020);
            default: ev = $urandom();
        endcase
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                text_q.push_back("0");
        add_str($sformatf("%0d", ev));
        // terminator: NUL half the time, else a blank or some other non-digit byte
        if ($urandom_range(0, 1))
            text_q.push_back(8'h00);
        else if ($urandom_range(0, 1))
            text_q.push_back(blank_char());
        else
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b >= "0" && b <= "9");
            text_q.push_back(b);
        end
        // bytes after the result are dropped by the parser
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // nan / inf in mixed case, sometimes signed or with a bad letter
    task automatic make_special();
        string word;
        text_q.delete();
        repeat ($urandom_range(0, 2))
            text_q.push_back(blank_char());
        case ($urandom_range(0, 3))
            1: text_q.push_back("+");
            2: text_q.push_back("-");
            default: ;
        endcase
        word = $urandom_range(0, 1) ? "nan" : "inf";
        for (int i = 0; i < 3; i++)
            text_q.push_back(flip_case(word[i]));
        if ($urandom_range(0, 4) == 0)
            text_q[text_q.size() - 1 - $urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // break a built literal: overwrite one byte or cut it short
    task automatic corrupt_text();
        int idx;
        idx = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 2) == 0)
            while (text_q.size() > idx)
                void'(text_q.pop_back());
        else
            text_q[idx] = 8'($urandom_range(0, 255));
    endtask

    task automatic random_phase(int idle, int stall);
        int start_items;
        int sel;
        idle_pct    = idle;
        stall_pct   = stall;
        start_items = items_sent;
        while (items_sent - start_items < PHASE_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                make_literal();
                send_text();
            end
            else if (sel < 67)
            begin
                make_special();
                send_text();
            end
            else if (sel < 82)
            begin
                make_literal();
                corrupt_text();
                send_text();
            end
            else if (sel < 97)
            begin
                // raw noise, string_start only now and then
                repeat ($urandom_range(1, 6))
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            else
                drain();
        end
        // close any string in flight before the next config write
        run_str("nan");
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // parse straight out of reset, no string_start
        send_item("n", 1'b0);
        send_item("a", 1'b0);
        send_item("N", 1'b0);

        // directed: value forms, specials, range edges, format errors
        run_str("0x1p0");
        run_str("-0x1.8p+1");
        text_q.delete();
        for (int b = 9; b <= 13; b++)
            text_q.push_back(8'(b));
        add_str(" 0X1P0");
        text_q.push_back(8'h00);
        send_text();
        run_str("-inf");
        run_str("+INF");
        run_str("+nan");
        run_str("nax");
        run_str("iNx");
        run_str("-0x0.000p9");
        run_str("0xFFFFFFFFFFFFFFFFF.Fp0");
        run_str("0x1p16384");
        run_str("0x1p-16384");
        run_str("0x1p-16383");
        run_str("0x0.0001p-16300");
        run_str("0x1p999999999");
        run_str("0xg");
        run_str("0x.8p0");
        run_str("0x1.p");
        run_str("0x1p+");
        run_str("0x1p3x");
        run_str("");
        text_q.delete();
        add_str("0x7.fp-2");
        text_q.push_back(8'hFF);
        send_text();

        // strict: only NUL may end the exponent digits
        write_strict(1'b1);
        run_str("0x1p3");
        run_str("0x1p3x");
        run_str("0x1p3 ");
        text_q.delete();
        add_str("0xAp0");
        text_q.push_back(8'hFF);
        send_text();
        write_strict(1'b0);

        // long digit runs: truncated integer digits and a deep leading-zero fraction
        text_q.delete();
        add_str("0x1");
        repeat (LONG_RUN)
            text_q.push_back(hex_char($urandom_range(0, 15)));
        add_str("p0");
        text_q.push_back(8'h00);
        send_text();
        text_q.delete();
        add_str("-0x0.");
        repeat (LONG_RUN)
            text_q.push_back("0");
        add_str("1p0");
        text_q.push_back(8'h00);
        send_text();

        // random phases across the idling mixes and both config settings
        random_phase(0, 0);
        write_strict(1'b1);
        random_phase(83, 0);
        write_strict(1'b0);
        random_phase(0, 83);
        write_strict(1'b1);
        random_phase(9, 9);
        write_strict(1'b0);

        // back-pressure: receiver holds off while short result-heavy strings
        // keep coming, so the output stage fills and tready drops
        idle_pct  = 0;
        stall_pct = 0;
        hold_go  <= ~hold_go;
        repeat (30)
            if ($urandom_range(0, 1))
                run_str("nan");
            else
                run_str("x");
        drain();

        $display("covered %0d strings over %0d byte items, %0d results compared",
                 strings_sent, items_sent, checked);
        $display("both strict settings, all idle mixes, long digit runs, output back-pressure");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
